### rtl/core/shla_pkg.sv
// shla_pkg: shared types and constants for the sorted hole list allocator.
// Used by shla_hole_ram and sorted_hole_list_allocator. No dependencies.
`default_nettype none

package shla_pkg;

    localparam int HOLE_IDX_W = 4;
    localparam int HOLE_CNT_W = HOLE_IDX_W + 1;

    localparam logic [HOLE_CNT_W-1:0] MAX_HOLES    = 5'd16;
    localparam logic [15:0]           HEADER_BYTES = 16'd16;
    localparam logic [16:0]           HEAP_LIMIT   = 17'd65536;
    localparam logic [16:0]           HEAP_RESET   = 17'd65536;
    localparam logic [16:0]           FREE_MAX     = 17'h1FFFF;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_OOM       = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
    } hole_t;

    typedef struct packed {
        logic                  en;
        logic [HOLE_IDX_W-1:0] addr;
        hole_t                 data;
    } hole_wr_t;

endpackage

`default_nettype wire

### rtl/core/shla_hole_ram.sv
// shla_hole_ram: hole table storage, one write port and one registered read port.
// Depends on shla_pkg.
`default_nettype none

module shla_hole_ram (
    input  wire                           aclk,
    input  wire shla_pkg::hole_wr_t       wr,
    input  wire [shla_pkg::HOLE_IDX_W-1:0] rd_addr,
    output shla_pkg::hole_t               rd_data
);
    import shla_pkg::*;

    localparam int DEPTH = 1 << HOLE_IDX_W;

    hole_t mem [DEPTH];
    hole_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/sorted_hole_list_allocator.sv
// sorted_hole_list_allocator: best-fit heap allocator over 16-bit byte offsets.
// Depends on shla_pkg and shla_hole_ram.
//
// Usage:
//   Input channel s_*: one item is an allocate (s_opcode 0, s_req_size) or a
//   free (s_opcode 1, s_user_address, s_block_size). Result channel m_*: one
//   item per input, carrying granted address, status and free byte count.
//   cfg_wr_en / cfg_wr_data set heap_bytes; write only while the block is idle.
//   Holes live in a 16-entry table kept in size order. A small sequencer walks
//   it one entry per step through a single read port and one size comparator:
//   each visited entry takes a read step, then a compare or move step.
//   Too large / table full go straight to the result. Allocate searches
//   from index 0 for the first hole that fits, then moves later holes down
//   over it; with no fitting hole it bump allocates. Free moves larger holes
//   up from the end, then writes the new hole in the gap.
//   s_ready is high only while the sequencer is idle; one item at a time.
//   A stalled result holds in the output register; the sequencer waits in its
//   final state until the slot frees.
//   Reset: hole count 0, bump offset 0, free bytes 65536, heap_bytes 65536.
`default_nettype none

module sorted_hole_list_allocator (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_wr_en,
    input  wire [16:0] cfg_wr_data,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire        s_opcode,
    input  wire [15:0] s_req_size,
    input  wire [15:0] s_user_address,
    input  wire [15:0] s_block_size,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [15:0] m_granted_address,
    output logic [1:0]  m_status,
    output logic [16:0] m_free_bytes
);
    import shla_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_DEL_RD   = 4'd3;
    localparam logic [3:0] S_DEL_WR   = 4'd4;
    localparam logic [3:0] S_BUMP     = 4'd5;
    localparam logic [3:0] S_INS_RD   = 4'd6;
    localparam logic [3:0] S_INS_CMP  = 4'd7;
    localparam logic [3:0] S_INS_WR   = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [HOLE_CNT_W-1:0] idx_reg, idx_next;
    logic [HOLE_CNT_W-1:0] count_reg, count_next;
    logic [16:0]           bump_reg, bump_next;
    logic [16:0]           free_reg, free_next;
    logic [16:0]           heap_reg;
    logic [15:0]           req_reg, req_next;
    logic [15:0]           uaddr_reg, uaddr_next;
    logic [15:0]           bsize_reg, bsize_next;
    logic [15:0]           res_addr_reg, res_addr_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic                  m_valid_reg;
    logic [15:0]           m_addr_reg;
    logic [1:0]            m_status_reg;
    logic [16:0]           m_free_reg;

    logic [HOLE_CNT_W-1:0] idx_inc, idx_dec;
    hole_wr_t              wr;
    logic [HOLE_IDX_W-1:0] rd_addr;
    hole_t                 rd_data;

    logic [17:0] bump_addr, bump_end, give_sum;
    logic [16:0] limit;
    logic        bump_fail, out_free;
    logic [16:0] free_take, free_give;

    shla_hole_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_inc   = idx_reg + 5'd1;
    assign idx_dec   = idx_reg - 5'd1;
    assign limit     = (heap_reg < HEAP_LIMIT) ? heap_reg : HEAP_LIMIT;
    assign bump_addr = {1'b0, bump_reg} + {2'b00, HEADER_BYTES};
    assign bump_end  = bump_addr + {2'b00, req_reg} + 18'd1;
    assign bump_fail = (bump_addr > 18'h0FFFF) || (bump_end > {1'b0, limit});
    assign free_take = ({1'b0, req_reg} > free_reg) ? 17'd0 : free_reg - {1'b0, req_reg};
    assign give_sum  = {1'b0, free_reg} + {2'b00, bsize_reg};
    assign free_give = (give_sum > {1'b0, FREE_MAX}) ? FREE_MAX : give_sum[16:0];
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_addr_reg;
    assign m_status          = m_status_reg;
    assign m_free_bytes      = m_free_reg;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        bump_next       = bump_reg;
        free_next       = free_reg;
        req_next        = req_reg;
        uaddr_next      = uaddr_reg;
        bsize_next      = bsize_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        wr              = '0;
        rd_addr         = idx_reg[HOLE_IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next        = s_req_size;
                    uaddr_next      = s_user_address;
                    bsize_next      = s_block_size;
                    res_addr_next   = 16'd0;
                    res_status_next = ST_OK;
                    idx_next        = '0;
                    if (s_opcode == OP_ALLOC) begin
                        if ({1'b0, s_req_size} > heap_reg) begin
                            res_status_next = ST_TOO_LARGE;
                            state_next      = S_OUT;
                        end else if (count_reg == '0) begin
                            state_next = S_BUMP;
                        end else begin
                            state_next = S_SRCH_RD;
                        end
                    end else begin
                        if (count_reg == MAX_HOLES) begin
                            res_status_next = ST_FULL;
                            state_next      = S_OUT;
                        end else begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                end
            end
            S_SRCH_RD: begin
                rd_addr    = idx_reg[HOLE_IDX_W-1:0];
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (rd_data.size > req_reg) begin
                    res_addr_next = rd_data.start + HEADER_BYTES;
                    state_next    = S_DEL_RD;
                end else if (idx_inc < count_reg) begin
                    idx_next   = idx_inc;
                    state_next = S_SRCH_RD;
                end else begin
                    state_next = S_BUMP;
                end
            end
            S_DEL_RD: begin
                rd_addr = idx_inc[HOLE_IDX_W-1:0];
                if (idx_inc < count_reg) begin
                    state_next = S_DEL_WR;
                end else begin
                    count_next = count_reg - 5'd1;
                    free_next  = free_take;
                    state_next = S_OUT;
                end
            end
            S_DEL_WR: begin
                wr.en      = 1'b1;
                wr.addr    = idx_reg[HOLE_IDX_W-1:0];
                wr.data    = rd_data;
                idx_next   = idx_inc;
                state_next = S_DEL_RD;
            end
            S_BUMP: begin
                if (bump_fail) begin
                    res_status_next = ST_OOM;
                    res_addr_next   = 16'd0;
                end else begin
                    bump_next     = bump_end[16:0];
                    free_next     = free_take;
                    res_addr_next = bump_addr[15:0];
                end
                state_next = S_OUT;
            end
            S_INS_RD: begin
                rd_addr = idx_dec[HOLE_IDX_W-1:0];
                if (idx_reg == '0) begin
                    state_next = S_INS_WR;
                end else begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (rd_data.size > bsize_reg) begin
                    wr.en      = 1'b1;
                    wr.addr    = idx_reg[HOLE_IDX_W-1:0];
                    wr.data    = rd_data;
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                wr.en         = 1'b1;
                wr.addr       = idx_reg[HOLE_IDX_W-1:0];
                wr.data.start = uaddr_reg - HEADER_BYTES;
                wr.data.size  = bsize_reg;
                count_next    = count_reg + 5'd1;
                free_next     = free_give;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            count_reg   <= '0;
            bump_reg    <= '0;
            free_reg    <= HEAP_RESET;
            heap_reg    <= HEAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            bump_reg  <= bump_next;
            free_reg  <= free_next;
            if (cfg_wr_en) begin
                heap_reg <= cfg_wr_data;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        uaddr_reg      <= uaddr_next;
        bsize_reg      <= bsize_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_OUT && out_free) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
            m_free_reg   <= free_reg;
        end
    end

endmodule

`default_nettype wire
